// ===== hw/rtl/srfp_pkg.sv =====
// Package for the stepper response frame parser: function codes, field tags,
// payload length table and byte helpers. Depends on nothing; every other file imports it.
package srfp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 32;
    localparam int AXIS_COUNT        = 2;
    localparam int CNT_W             = 6;
    localparam int SNAP_BYTES        = 28;
    localparam int CFG_ADDR_W        = 8;
    localparam int ERR_SUM_W         = 48;

    localparam logic [7:0] CODE_POS      = 8'h36;
    localparam logic [7:0] CODE_ERR      = 8'h37;
    localparam logic [7:0] CODE_SPEED    = 8'h35;
    localparam logic [7:0] CODE_ENC      = 8'h31;
    localparam logic [7:0] CODE_VOLT     = 8'h26;
    localparam logic [7:0] CODE_CURR     = 8'h27;
    localparam logic [7:0] CODE_TEMP     = 8'h39;
    localparam logic [7:0] CODE_FLAGS    = 8'h3C;
    localparam logic [7:0] CODE_STATUS   = 8'h43;
    localparam logic [7:0] CODE_LAST_REG = 8'h1F;

    localparam logic [CFG_ADDR_W-1:0] REG_ADDR_AXIS0 = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_ADDR_AXIS1 = CFG_ADDR_W'(1);

    localparam logic [31:0]          CENTIDEG_SCALE = 32'd36000;
    localparam logic [ERR_SUM_W-1:0] CENTIDEG_ROUND = ERR_SUM_W'(32768);
    localparam logic [31:0]          CENTIDEG_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        TAG_POS      = 4'd0,
        TAG_SPEED    = 4'd1,
        TAG_ENC      = 4'd2,
        TAG_ERR_CDEG = 4'd3,
        TAG_VOLT     = 4'd4,
        TAG_CURR     = 4'd5,
        TAG_TEMP     = 4'd6,
        TAG_HOME     = 4'd7,
        TAG_MOTOR    = 4'd8,
        TAG_ACK      = 4'd9,
        TAG_REF_POS  = 4'd10,
        TAG_ERR_RAW  = 4'd11
    } tag_t;

    typedef logic [SNAP_BYTES-1:0][7:0] payload_t;

    // Snapshot of a completed frame, handed from the parser to the emitter.
    typedef struct packed {
        logic                 axis;
        logic [7:0]           code;
        payload_t             bytes;
        logic [ERR_SUM_W-1:0] err_sum;
    } frame_t;

    // Bytes after the function code, check byte included.
    function automatic logic [CNT_W-1:0] length_for(input logic [7:0] code);
        logic [CNT_W-1:0] len;
        case (code)
            CODE_POS, CODE_ERR: len = CNT_W'(6);
            CODE_SPEED:         len = CNT_W'(4);
            CODE_ENC, CODE_VOLT, CODE_CURR, CODE_TEMP, CODE_FLAGS: len = CNT_W'(3);
            CODE_STATUS:        len = CNT_W'(CODE_LAST_REG - 8'd2);
            default:            len = CNT_W'(2);
        endcase
        return len;
    endfunction

    function automatic logic [3:0] updates_for(input logic [7:0] code);
        logic [3:0] n;
        case (code)
            CODE_STATUS: n = 4'd10;
            CODE_FLAGS:  n = 4'd2;
            default:     n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] be16(input payload_t p, input int i);
        return {16'd0, p[i], p[i+1]};
    endfunction

    function automatic logic [31:0] be32(input payload_t p, input int i);
        return {p[i], p[i+1], p[i+2], p[i+3]};
    endfunction

endpackage

// ===== hw/rtl/srfp_if.sv =====
// Channel interfaces of the frame parser: received bytes, field updates and
// register writes. Depends on srfp_pkg for widths.
interface srfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfp_upd_if;
    logic               valid;
    logic               ready;
    logic               axis_index;
    logic [7:0]         function_code;
    logic [3:0]         field_tag;
    logic signed [32:0] field_value;
    logic               last_update;

    modport source (output valid, output axis_index, output function_code,
                    output field_tag, output field_value, output last_update,
                    input ready);
    modport sink   (input valid, input axis_index, input function_code,
                    input field_tag, input field_value, input last_update,
                    output ready);
endinterface

interface srfp_cfg_if;
    import srfp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [7:0]            data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hw/rtl/stepper_response_frame_parser_unit.sv =====
// Top level of the stepper response frame parser: byte parser and update emitter.
// Depends on srfp_pkg, srfp_if, srfp_parser and srfp_emitter.
//
//   channel  dir   transfer                        payload
//   rx       in    rx.valid & rx.ready             rx_byte
//   upd      out   upd.valid & upd.ready           axis, code, tag, value, last
//   cfg      in    cfg.valid & cfg.ready (always)  addr, data
//
// One received byte is taken per cycle while rx.ready is high. The byte that
// closes a frame hands a snapshot to the emitter, whose updates pass through its
// snapshot register and then the output register: 1, 2 or 10 per frame, one per cycle
// while upd.ready is high. The next frame's closing byte is held off while the emitter drains.
// Reset is asynchronous and active low; the payload store needs no clearing.
module stepper_response_frame_parser_unit
    import srfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    srfp_rx_if.sink     rx,
    srfp_upd_if.source  upd,
    srfp_cfg_if.sink    cfg
);

    logic   frame_valid;
    frame_t frame;
    logic   emit_busy;

    srfp_parser #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .cfg         (cfg),
        .emit_busy   (emit_busy),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    srfp_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .busy        (emit_busy),
        .upd         (upd)
    );

    // A new snapshot never lands on a frame that is still being sent.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> !emit_busy)
        else $error("frame snapshot while emitter busy");

    // Updates of one frame follow back to back with the same axis and code.
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.valid && upd.ready && !upd.last_update) |=>
            (upd.valid && $stable(upd.function_code) && $stable(upd.axis_index)))
        else $error("frame updates not contiguous");

    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        upd.valid |-> (upd.field_tag <= TAG_ERR_RAW))
        else $error("field tag out of range");

endmodule

// ===== hw/rtl/srfp_parser.sv =====
// Byte-level frame parser: address match, function code, payload collection
// and frame snapshot. Depends on srfp_pkg and srfp_if.
module srfp_parser
    import srfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    srfp_rx_if.sink     rx,
    srfp_cfg_if.sink    cfg,
    input  logic        emit_busy,
    output logic        frame_valid,
    output frame_t      frame
);

    localparam int IDX_W = $clog2(PAYLOAD_DEPTH);

    typedef enum logic [1:0] {
        PH_ADDR = 2'd0,
        PH_CODE = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             axis_reg, axis_next;
    logic [7:0]       code_reg, code_next;
    logic [CNT_W-1:0] rcvd_reg, rcvd_next;
    logic [CNT_W-1:0] expect_reg, expect_next;
    logic [7:0]       addr0_reg, addr0_next;
    logic [7:0]       addr1_reg, addr1_next;
    logic [7:0]       store [PAYLOAD_DEPTH];

    logic             room;
    logic [CNT_W-1:0] rcvd_inc;
    logic             last_pending;
    logic             take;
    payload_t         snap;

    assign room         = {1'b0, rcvd_reg} < (CNT_W + 1)'(PAYLOAD_DEPTH);
    assign rcvd_inc     = room ? rcvd_reg + CNT_W'(1) : rcvd_reg;
    assign last_pending = (phase_reg == PH_DATA) && (rcvd_inc >= expect_reg);

    // The byte that closes a frame waits until the previous frame has drained.
    assign rx.ready  = !(last_pending && emit_busy);
    assign take      = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        axis_next   = axis_reg;
        code_next   = code_reg;
        rcvd_next   = rcvd_reg;
        expect_next = expect_reg;
        addr0_next  = addr0_reg;
        addr1_next  = addr1_reg;
        if (cfg.valid)
        begin
            if (cfg.addr == REG_ADDR_AXIS0)
            begin
                addr0_next = cfg.data;
            end
            else if (cfg.addr == REG_ADDR_AXIS1)
            begin
                addr1_next = cfg.data;
            end
        end
        if (take)
        begin
            unique case (phase_reg)
                PH_ADDR:
                begin
                    if (rx.rx_byte == addr0_reg)
                    begin
                        axis_next  = 1'b0;
                        phase_next = PH_CODE;
                    end
                    else if (AXIS_COUNT > 1 && rx.rx_byte == addr1_reg)
                    begin
                        axis_next  = 1'b1;
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    code_next   = rx.rx_byte;
                    rcvd_next   = '0;
                    expect_next = length_for(rx.rx_byte);
                    phase_next  = PH_DATA;
                end
                PH_DATA:
                begin
                    rcvd_next = rcvd_inc;
                    if (last_pending)
                    begin
                        phase_next = PH_ADDR;
                    end
                end
                default:
                begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ADDR;
            axis_reg   <= 1'b0;
            code_reg   <= '0;
            rcvd_reg   <= '0;
            expect_reg <= '0;
            addr0_reg  <= 8'd1;
            addr1_reg  <= 8'd2;
        end
        else
        begin
            phase_reg  <= phase_next;
            axis_reg   <= axis_next;
            code_reg   <= code_next;
            rcvd_reg   <= rcvd_next;
            expect_reg <= expect_next;
            addr0_reg  <= addr0_next;
            addr1_reg  <= addr1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && phase_reg == PH_DATA && room)
        begin
            store[rcvd_reg[IDX_W-1:0]] <= rx.rx_byte;
        end
    end

    // The closing byte is the check byte, so the stored bytes hold all fields.
    always_comb
    begin
        for (int i = 0; i < SNAP_BYTES; i++)
        begin
            snap[i] = store[i];
        end
    end

    assign frame_valid   = take && last_pending;
    assign frame.axis    = axis_reg;
    assign frame.code    = code_reg;
    assign frame.bytes   = snap;
    assign frame.err_sum = ERR_SUM_W'(be32(snap, 22)) * ERR_SUM_W'(CENTIDEG_SCALE)
                           + CENTIDEG_ROUND;

endmodule

// ===== hw/rtl/srfp_emitter.sv =====
// Field update sequencer: holds one frame snapshot and sends its updates one per cycle
// through an output register while upd.ready is high. Depends on srfp_pkg and srfp_if.
module srfp_emitter
    import srfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    input  frame_t      frame,
    output logic        busy,
    srfp_upd_if.source  upd
);

    frame_t             rec_reg;
    logic               busy_reg, busy_next;
    logic [3:0]         step_reg, step_next;
    logic               ovalid_reg, ovalid_next;
    logic               oaxis_reg;
    logic [7:0]         ocode_reg;
    tag_t               otag_reg;
    logic signed [32:0] oval_reg;
    logic               olast_reg;

    logic               advance;
    logic               step_last;
    tag_t               sel_tag;
    logic               sel_signed;
    logic [7:0]         sel_sign;
    logic [31:0]        sel_mag;
    logic [31:0]        cdeg_raw;
    logic [31:0]        cdeg_sat;
    logic [32:0]        mag33;
    logic signed [32:0] sel_val;
    payload_t           p;

    assign p         = rec_reg.bytes;
    assign advance   = busy_reg && (!ovalid_reg || upd.ready);
    assign step_last = (step_reg == updates_for(rec_reg.code) - 4'd1);
    assign busy      = busy_reg;

    assign cdeg_raw = rec_reg.err_sum[ERR_SUM_W-1:ERR_SUM_W-32];
    assign cdeg_sat = cdeg_raw[31] ? CENTIDEG_MAX : cdeg_raw;

    always_comb
    begin
        sel_tag    = TAG_ACK;
        sel_signed = 1'b0;
        sel_sign   = p[0];
        sel_mag    = {24'd0, p[0]};
        case (rec_reg.code)
            CODE_POS:
            begin
                sel_tag = TAG_POS;  sel_signed = 1'b1; sel_mag = be32(p, 1);
            end
            CODE_SPEED:
            begin
                sel_tag = TAG_SPEED; sel_signed = 1'b1; sel_mag = be16(p, 1);
            end
            CODE_ENC:
            begin
                sel_tag = TAG_ENC;  sel_mag = be16(p, 0);
            end
            CODE_ERR:
            begin
                sel_tag = TAG_ERR_CDEG; sel_signed = 1'b1; sel_mag = be32(p, 1);
            end
            CODE_VOLT:
            begin
                sel_tag = TAG_VOLT; sel_mag = be16(p, 0);
            end
            CODE_CURR:
            begin
                sel_tag = TAG_CURR; sel_mag = be16(p, 0);
            end
            CODE_TEMP:
            begin
                sel_tag = TAG_TEMP; sel_signed = 1'b1; sel_mag = {24'd0, p[1]};
            end
            CODE_FLAGS:
            begin
                if (step_reg == 4'd0)
                begin
                    sel_tag = TAG_HOME;  sel_mag = {24'd0, p[0]};
                end
                else
                begin
                    sel_tag = TAG_MOTOR; sel_mag = {24'd0, p[1]};
                end
            end
            CODE_STATUS:
            begin
                case (step_reg)
                    4'd0:    begin sel_tag = TAG_VOLT; sel_mag = be16(p, 2); end
                    4'd1:    begin sel_tag = TAG_CURR; sel_mag = be16(p, 4); end
                    4'd2:    begin sel_tag = TAG_ENC;  sel_mag = be16(p, 6); end
                    4'd3:
                    begin
                        sel_tag = TAG_REF_POS; sel_signed = 1'b1;
                        sel_sign = p[8];  sel_mag = be32(p, 9);
                    end
                    4'd4:
                    begin
                        sel_tag = TAG_SPEED; sel_signed = 1'b1;
                        sel_sign = p[13]; sel_mag = be16(p, 14);
                    end
                    4'd5:
                    begin
                        sel_tag = TAG_POS; sel_signed = 1'b1;
                        sel_sign = p[16]; sel_mag = be32(p, 17);
                    end
                    4'd6:
                    begin
                        sel_tag = TAG_ERR_RAW; sel_signed = 1'b1;
                        sel_sign = p[21]; sel_mag = be32(p, 22);
                    end
                    4'd7:
                    begin
                        sel_tag = TAG_ERR_CDEG; sel_signed = 1'b1;
                        sel_sign = p[21]; sel_mag = cdeg_sat;
                    end
                    4'd8:    begin sel_tag = TAG_HOME;  sel_mag = {24'd0, p[26]}; end
                    default: begin sel_tag = TAG_MOTOR; sel_mag = {24'd0, p[27]}; end
                endcase
            end
            default:
            begin
                sel_tag = TAG_ACK;
            end
        endcase
    end

    // For a signed field, a nonzero sign byte negates the magnitude.
    assign mag33   = {1'b0, sel_mag};
    assign sel_val = (sel_signed && sel_sign != 8'd0) ? $signed(-mag33) : $signed(mag33);

    always_comb
    begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg;
        if (upd.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (advance)
        begin
            ovalid_next = 1'b1;
            step_next   = step_reg + 4'd1;
            if (step_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (frame_valid)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid)
        begin
            rec_reg <= frame;
        end
        if (advance)
        begin
            oaxis_reg <= rec_reg.axis;
            ocode_reg <= rec_reg.code;
            otag_reg  <= sel_tag;
            oval_reg  <= sel_val;
            olast_reg <= step_last;
        end
    end

    assign upd.valid         = ovalid_reg;
    assign upd.axis_index    = oaxis_reg;
    assign upd.function_code = ocode_reg;
    assign upd.field_tag     = otag_reg;
    assign upd.field_value   = oval_reg;
    assign upd.last_update   = olast_reg;

endmodule
